// ===== hdl/lds_pkg.sv =====
package lds_pkg;

  // Field widths of the byte and result words.
  localparam int BYTE_W  = 8;
  localparam int CODE_W  = 3;
  localparam int WORD_W  = 64;
  localparam int NWORDS  = 4;
  localparam int COUNT_W = 6;
  localparam int LBL_W   = 7;

  // Default width of the body length counter.
  localparam int LENGTH_BITS_DEFAULT = 16;

  // DER constants.
  localparam logic [BYTE_W-1:0]  SEQ_TAG        = 8'h30;
  localparam logic [BYTE_W-1:0]  INT_TAG        = 8'h02;
  localparam logic [COUNT_W-1:0] MAX_INT_BYTES  = 6'd32;
  localparam logic [COUNT_W-1:0] COUNT_SAT      = 6'd33;

  // Result codes.
  typedef enum logic [CODE_W-1:0] {
    ERR_NONE    = 3'd0,
    ERR_SEQ_TAG = 3'd1,
    ERR_R_TAG   = 3'd2,
    ERR_S_TAG   = 3'd3,
    ERR_TRUNC   = 3'd4,
    ERR_R_LONG  = 3'd5,
    ERR_S_LONG  = 3'd6
  } err_t;

  // One parsed signature as handed from the parser to the output stage.
  typedef struct packed {
    logic                           valid_res;
    err_t                           error_code;
    logic [NWORDS-1:0][WORD_W-1:0]  r_words;
    logic [NWORDS-1:0][WORD_W-1:0]  s_words;
  } result_t;

endpackage

// ===== hdl/lds_in_if.sv =====
interface lds_in_if;
  import lds_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] sig_byte;
  logic              last_byte;

  modport source (output valid, output sig_byte, output last_byte, input ready);
  modport sink   (input valid, input sig_byte, input last_byte, output ready);

endinterface

// ===== hdl/lds_out_if.sv =====
interface lds_out_if;
  import lds_pkg::*;

  logic              valid;
  logic              ready;
  logic              valid_res;
  logic [CODE_W-1:0] error_code;
  logic [WORD_W-1:0] r_word3;
  logic [WORD_W-1:0] r_word2;
  logic [WORD_W-1:0] r_word1;
  logic [WORD_W-1:0] r_word0;
  logic [WORD_W-1:0] s_word3;
  logic [WORD_W-1:0] s_word2;
  logic [WORD_W-1:0] s_word1;
  logic [WORD_W-1:0] s_word0;

  modport source (
    output valid, output valid_res, output error_code,
    output r_word3, output r_word2, output r_word1, output r_word0,
    output s_word3, output s_word2, output s_word1, output s_word0,
    input ready
  );
  modport sink (
    input valid, input valid_res, input error_code,
    input r_word3, input r_word2, input r_word1, input r_word0,
    input s_word3, input s_word2, input s_word1, input s_word0,
    output ready
  );

endinterface

// ===== hdl/lax_der_signature_parser.sv =====
// DER signature parser, one byte per word.
// Channel sig carries sig_byte and last_byte; a word moves when valid and
// ready are both high. The byte flagged last_byte closes a signature, and
// the next word starts a new one.
// Channel res carries one word per signature: valid_res, error_code and
// R and S as four 64-bit words each, most significant first. R and S are
// zero whenever valid_res is low.
// The result appears on res in the cycle after its last byte is
// accepted. Throughput: one byte per cycle while sig ready is high, set
// by the single register stage of parser state.
// Reset (rst, synchronous, active high) returns the parser to the start
// of a signature and empties the result register.
// When the receiver stalls, the waiting result is held, and sig ready is
// low in every cycle in which a result waits and res ready is low; when
// the held result is taken, a new byte can be accepted in the same cycle.
module lax_der_signature_parser #(
  parameter int LENGTH_BITS = lds_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  lds_in_if.sink    sig,
  lds_out_if.source res
);
  import lds_pkg::*;

  logic    busy;
  logic    accept;
  logic    fire;
  result_t result;

  assign sig.ready = !busy;
  assign accept    = sig.valid && sig.ready;

  lds_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .sig_byte  (sig.sig_byte),
    .last_byte (sig.last_byte),
    .fire      (fire),
    .result    (result)
  );

  lds_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .load   (fire),
    .result (result),
    .busy   (busy),
    .res    (res)
  );

endmodule

// ===== hdl/lds_parser.sv =====
module lds_parser #(
  parameter int LENGTH_BITS = lds_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic [lds_pkg::BYTE_W-1:0]  sig_byte,
  input  logic                        last_byte,
  output logic                        fire,
  output lds_pkg::result_t            result
);
  import lds_pkg::*;

  typedef enum logic [3:0] {
    PH_SEQ_TAG  = 4'd0,
    PH_SEQ_LEN  = 4'd1,
    PH_SEQ_SKIP = 4'd2,
    PH_R_TAG    = 4'd3,
    PH_R_LEN    = 4'd4,
    PH_R_LENB   = 4'd5,
    PH_R_BODY   = 4'd6,
    PH_S_TAG    = 4'd7,
    PH_S_LEN    = 4'd8,
    PH_S_LENB   = 4'd9,
    PH_S_BODY   = 4'd10,
    PH_DONE     = 4'd11,
    PH_FAILED   = 4'd12
  } phase_t;

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

  // Parser state.
  phase_t                        parse_phase;
  logic [LENGTH_BITS-1:0]        length_left;
  logic [LBL_W-1:0]              length_bytes_left;
  logic [NWORDS*WORD_W-1:0]      r_shift;
  logic [NWORDS*WORD_W-1:0]      s_shift;
  logic [COUNT_W-1:0]            significant_count;
  logic                          saw_nonzero;
  err_t                          first_error;
  logic                          r_too_long;
  logic                          s_too_long;

  // Next values after the current byte.
  phase_t                        parse_phase_next;
  logic [LENGTH_BITS-1:0]        length_left_next;
  logic [LBL_W-1:0]              length_bytes_left_next;
  logic [NWORDS*WORD_W-1:0]      r_shift_next;
  logic [NWORDS*WORD_W-1:0]      s_shift_next;
  logic [COUNT_W-1:0]            significant_count_next;
  logic                          saw_nonzero_next;
  err_t                          first_error_next;
  logic                          r_too_long_next;
  logic                          s_too_long_next;

  logic                          start_body;
  logic                          finish_part;
  logic [LENGTH_BITS-1:0]        start_len;
  logic                          in_r_part;
  logic [LBL_W-1:0]              lbl_dec;
  logic [LENGTH_BITS-1:0]        len_dec;
  logic [LENGTH_BITS-1:0]        len_acc;
  logic                          take_byte;
  logic [COUNT_W-1:0]            count_inc;
  err_t                          code;

  // Helpers shared by several phases.
  assign in_r_part = (parse_phase == PH_R_LEN) || (parse_phase == PH_R_LENB) ||
                     (parse_phase == PH_R_BODY);
  assign lbl_dec   = length_bytes_left - LBL_W'(1);
  assign len_dec   = length_left - LENGTH_BITS'(1);
  assign len_acc   = (length_left[LENGTH_BITS-1 -: BYTE_W] != '0) ? LEN_MAX :
                     ((length_left << BYTE_W) | LENGTH_BITS'(sig_byte));
  assign take_byte = saw_nonzero || (sig_byte != '0);
  assign count_inc = (significant_count < COUNT_SAT) ?
                     significant_count + COUNT_W'(1) : significant_count;

  // Consume one byte.
  always_comb begin
    parse_phase_next       = parse_phase;
    length_left_next       = length_left;
    length_bytes_left_next = length_bytes_left;
    r_shift_next           = r_shift;
    s_shift_next           = s_shift;
    significant_count_next = significant_count;
    saw_nonzero_next       = saw_nonzero;
    first_error_next       = first_error;
    r_too_long_next        = r_too_long;
    s_too_long_next        = s_too_long;
    start_body             = 1'b0;
    finish_part            = 1'b0;
    start_len              = '0;

    unique case (parse_phase)
      PH_SEQ_TAG: begin
        if (sig_byte == SEQ_TAG) begin
          parse_phase_next = PH_SEQ_LEN;
        end else begin
          first_error_next = ERR_SEQ_TAG;
          parse_phase_next = PH_FAILED;
        end
      end
      PH_SEQ_LEN: begin
        if (sig_byte[BYTE_W-1]) begin
          length_bytes_left_next = sig_byte[LBL_W-1:0];
          parse_phase_next = (sig_byte[LBL_W-1:0] == '0) ? PH_R_TAG : PH_SEQ_SKIP;
        end else begin
          parse_phase_next = PH_R_TAG;
        end
      end
      PH_SEQ_SKIP: begin
        length_bytes_left_next = lbl_dec;
        if (lbl_dec == '0) begin
          parse_phase_next = PH_R_TAG;
        end
      end
      PH_R_TAG, PH_S_TAG: begin
        if (sig_byte == INT_TAG) begin
          parse_phase_next = (parse_phase == PH_R_TAG) ? PH_R_LEN : PH_S_LEN;
        end else begin
          first_error_next = (parse_phase == PH_R_TAG) ? ERR_R_TAG : ERR_S_TAG;
          parse_phase_next = PH_FAILED;
        end
      end
      PH_R_LEN, PH_S_LEN: begin
        if (sig_byte[BYTE_W-1]) begin
          length_bytes_left_next = sig_byte[LBL_W-1:0];
          length_left_next = '0;
          if (sig_byte[LBL_W-1:0] == '0) begin
            start_body = 1'b1;
          end else begin
            parse_phase_next = (parse_phase == PH_R_LEN) ? PH_R_LENB : PH_S_LENB;
          end
        end else begin
          start_body = 1'b1;
          start_len  = LENGTH_BITS'(sig_byte);
        end
      end
      PH_R_LENB, PH_S_LENB: begin
        length_left_next       = len_acc;
        length_bytes_left_next = lbl_dec;
        if (lbl_dec == '0) begin
          start_body = 1'b1;
          start_len  = len_acc;
        end
      end
      PH_R_BODY, PH_S_BODY: begin
        if (take_byte) begin
          saw_nonzero_next       = 1'b1;
          significant_count_next = count_inc;
          if (parse_phase == PH_R_BODY) begin
            r_shift_next = {r_shift[NWORDS*WORD_W-BYTE_W-1:0], sig_byte};
          end else begin
            s_shift_next = {s_shift[NWORDS*WORD_W-BYTE_W-1:0], sig_byte};
          end
        end
        length_left_next = len_dec;
        if (len_dec == '0) begin
          finish_part = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Enter a body; an empty body ends the part at once.
    if (start_body) begin
      length_left_next       = start_len;
      significant_count_next = '0;
      saw_nonzero_next       = 1'b0;
      if (start_len == '0) begin
        finish_part = 1'b1;
      end else begin
        parse_phase_next = in_r_part ? PH_R_BODY : PH_S_BODY;
      end
    end

    // Close R or S and note whether it fit.
    if (finish_part) begin
      if (in_r_part) begin
        r_too_long_next  = significant_count_next > MAX_INT_BYTES;
        parse_phase_next = PH_S_TAG;
      end else begin
        s_too_long_next  = significant_count_next > MAX_INT_BYTES;
        parse_phase_next = PH_DONE;
      end
      significant_count_next = '0;
      saw_nonzero_next       = 1'b0;
    end
  end

  // Result code from the state after this byte.
  always_comb begin
    priority if (parse_phase_next == PH_FAILED) begin
      code = first_error_next;
    end else if (parse_phase_next != PH_DONE) begin
      code = ERR_TRUNC;
    end else if (r_too_long_next) begin
      code = ERR_R_LONG;
    end else if (s_too_long_next) begin
      code = ERR_S_LONG;
    end else begin
      code = ERR_NONE;
    end
  end

  assign fire              = accept && last_byte;
  assign result.valid_res  = (code == ERR_NONE);
  assign result.error_code = code;
  assign result.r_words    = (code == ERR_NONE) ? r_shift_next : '0;
  assign result.s_words    = (code == ERR_NONE) ? s_shift_next : '0;

  // State registers; the last byte of a signature returns to the start.
  always_ff @(posedge clk) begin
    if (rst || fire) begin
      parse_phase       <= PH_SEQ_TAG;
      length_left       <= '0;
      length_bytes_left <= '0;
      r_shift           <= '0;
      s_shift           <= '0;
      significant_count <= '0;
      saw_nonzero       <= 1'b0;
      first_error       <= ERR_NONE;
      r_too_long        <= 1'b0;
      s_too_long        <= 1'b0;
    end else if (accept) begin
      parse_phase       <= parse_phase_next;
      length_left       <= length_left_next;
      length_bytes_left <= length_bytes_left_next;
      r_shift           <= r_shift_next;
      s_shift           <= s_shift_next;
      significant_count <= significant_count_next;
      saw_nonzero       <= saw_nonzero_next;
      first_error       <= first_error_next;
      r_too_long        <= r_too_long_next;
      s_too_long        <= s_too_long_next;
    end
  end

endmodule

// ===== hdl/lds_out_stage.sv =====
module lds_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  lds_pkg::result_t  result,
  output logic              busy,
  lds_out_if.source         res
);
  import lds_pkg::*;

  logic    full;
  result_t held;

  // Result register: loaded on the last byte, emptied when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (res.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  // The stage blocks new bytes only while a result waits and is not taken.
  assign busy           = full && !res.ready;
  assign res.valid      = full;
  assign res.valid_res  = held.valid_res;
  assign res.error_code = held.error_code;
  assign res.r_word3    = held.r_words[3];
  assign res.r_word2    = held.r_words[2];
  assign res.r_word1    = held.r_words[1];
  assign res.r_word0    = held.r_words[0];
  assign res.s_word3    = held.s_words[3];
  assign res.s_word2    = held.s_words[2];
  assign res.s_word1    = held.s_words[1];
  assign res.s_word0    = held.s_words[0];

`ifndef SYNTHESIS
  // A waiting result is never overwritten.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> !busy)
    else $error("result overwritten while stalled");

  // The valid flag agrees with the code.
  a_flag_code: assert property (@(posedge clk) disable iff (rst)
    full |-> (held.valid_res == (held.error_code == ERR_NONE)))
    else $error("valid_res disagrees with error_code");

  // A failed parse carries no R or S.
  a_zero_on_error: assert property (@(posedge clk) disable iff (rst)
    (full && !held.valid_res) |-> (held.r_words == '0 && held.s_words == '0))
    else $error("nonzero R or S on an invalid result");
`endif

endmodule
